@@ rtl/rdc_pkg.sv @@
// Shared types, constants and the digit character table for the radix digit converter.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package rdc_pkg;

    // Defaults for the top-level parameters.
    localparam int WORD_BITS_DEF  = 32;
    localparam int MAX_DIGITS_DEF = 32;

    // Fixed field widths of the stream payload.
    localparam int VALUE_W = 32;
    localparam int BASE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int REM_W   = 6;

    // Valid radix range.
    localparam logic [BASE_W-1:0] BASE_MIN = 8'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 8'd36;

    // Status codes carried in tuser.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_BASE = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

    // Status of the bit-serial divider, seen by the controller.
    typedef struct packed {
        logic             done;  // one-cycle pulse after the last quotient bit
        logic             qnz;   // quotient is nonzero
        logic [REM_W-1:0] rem;   // remainder of the finished division
    } t_div_status;

    // Maps a digit value to its ASCII character, 0-9 then A-Z.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d < 6'd36) begin
            c = CHAR_A + CHAR_W'(d - 6'd10);
        end else begin
            c = CHAR_NONE;
        end
        return c;
    endfunction

endpackage

@@ rtl/rdc_serial_div.sv @@
// Restoring divider of a WORD_BITS dividend by a small radix, one quotient bit per cycle.
// Depends on rdc_pkg for the remainder width and the status struct.
`timescale 1ns / 1ps

module rdc_serial_div
    import rdc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [REM_W-1:0]     i_base,
    output logic [WORD_BITS-1:0] o_quotient,
    output t_div_status          o_status
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] r_q;
    logic [REM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_qnz;

    logic [REM_W:0]   w_shift;
    logic [REM_W:0]   w_diff;
    logic             w_ge;
    logic [REM_W-1:0] n_rem;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign w_shift = {r_rem, r_q[WORD_BITS-1]};
    assign w_diff  = w_shift - {1'b0, i_base};
    assign w_ge    = (w_shift >= {1'b0, i_base});
    assign n_rem   = w_ge ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_qnz  <= 1'b0;
                r_cnt  <= CNT_W'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_q   <= {r_q[WORD_BITS-2:0], w_ge};
                r_rem <= n_rem;
                r_qnz <= r_qnz | w_ge;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_quotient    = r_q;
    assign o_status.done = r_done;
    assign o_status.qnz  = r_qnz;
    assign o_status.rem  = r_rem;

endmodule

@@ rtl/radix_digit_converter_core.sv @@
// Top level of the radix digit converter: stream ports, digit store and emit control.
// Depends on rdc_pkg and rdc_serial_div.
`timescale 1ns / 1ps

// Converts an unsigned number to ASCII digits in radix 2..36 and streams them out most
// significant first, with tlast on the final character. Each digit costs one pass of the
// bit-serial divider, and each emitted character then passes through a store read, a table
// lookup and the output register, and waits out any output stall. A radix outside 2..36
// gives one character of code zero, with tuser set. One request is worked at a time;
// tready is high only when idle.
module radix_digit_converter_core
    import rdc_pkg::*;
#(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] value_in, [39:32] target_base
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] digit_char, [7] zero fill
    output logic [0:0]  o_m_axis_tuser,   // [0] status
    output logic        o_m_axis_tlast    // last_digit
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int NUM_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [REM_W-1:0]    r_base;
    logic [NUM_W-1:0]    r_n;
    logic [IDX_W-1:0]    r_idx;
    logic [REM_W-1:0]    r_rd;
    logic [CHAR_W-1:0]   r_ochar;
    logic                r_ostat;
    logic                r_olast;
    logic                r_ovalid;

    logic [REM_W-1:0]    digit_store [MAX_DIGITS];

    logic [VALUE_W-1:0]   w_value;
    logic [BASE_W-1:0]    w_base_in;
    logic [63:0]          w_value64;
    logic [WORD_BITS-1:0] w_value_masked;
    logic                 w_base_ok;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_more;
    logic                 w_start;
    logic [WORD_BITS-1:0] w_dividend;
    logic [WORD_BITS-1:0] w_quotient;
    t_div_status          w_div;

    assign w_value        = i_s_axis_tdata[VALUE_W-1:0];
    assign w_base_in      = i_s_axis_tdata[VALUE_W +: BASE_W];
    assign w_value64      = {{(64 - VALUE_W){1'b0}}, w_value};
    assign w_value_masked = w_value64[WORD_BITS-1:0];
    assign w_base_ok      = (w_base_in >= BASE_MIN) && (w_base_in <= BASE_MAX);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_ovalid && i_m_axis_tready;

    // Keep dividing while the quotient is nonzero and the store has room.
    assign w_more  = w_div.qnz && (r_n != NUM_W'(MAX_DIGITS - 1));
    assign w_start = (w_in_acc && w_base_ok) ||
                     ((r_state == ST_DIV) && w_div.done && w_more);
    assign w_dividend = (r_state == ST_IDLE) ? w_value_masked : w_quotient;

    rdc_serial_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_base     (r_state == ST_IDLE ? w_base_in[REM_W-1:0] : r_base),
        .o_quotient (w_quotient),
        .o_status   (w_div)
    );

    // Remainders are stored least significant first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DIV) && w_div.done) begin
            digit_store[r_n[IDX_W-1:0]] <= w_div.rem;
        end
        r_rd <= digit_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_n      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (w_base_ok) begin
                            r_base  <= w_base_in[REM_W-1:0];
                            r_n     <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_ochar  <= CHAR_NONE;
                            r_ostat  <= STATUS_BAD_BASE;
                            r_olast  <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_n      <= '0;
                            r_state  <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        r_n <= r_n + 1'b1;
                        if (!w_more) begin
                            r_idx   <= r_n[IDX_W-1:0];
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    r_ochar  <= digit_char(r_rd);
                    r_ostat  <= STATUS_OK;
                    r_olast  <= (r_idx == '0);
                    r_ovalid <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_acc) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_ochar};
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;

endmodule

@@ verif/rdc_digit_checker.sv @@
// Checker for the radix digit converter: watches both stream channels, predicts the digit
// characters of each accepted request and compares them with the emitted ones.
// Depends on rdc_pkg for field widths, status codes and character constants.
`timescale 1ns / 1ps

module rdc_digit_checker
    import rdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,    // [31:0] value_in, [39:32] target_base
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [6:0] digit_char, [7] zero fill
    input  logic [0:0]  i_m_tuser,    // [0] status
    input  logic        i_m_tlast,    // last_digit
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              status;
        logic              last;
    } t_digit_rec;

    t_digit_rec digit_q[$];

    // Repeated division by the radix; remainders come out least significant first and
    // are queued most significant first.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                           input logic [BASE_W-1:0] radix);
        logic [REM_W-1:0]   rems[MAX_DIGITS_DEF];
        logic [VALUE_W-1:0] quo;
        logic [REM_W-1:0]   d;
        logic [CHAR_W-1:0]  ch;
        int                 n;
        n = 0;
        if (radix < BASE_MIN || radix > BASE_MAX) begin
            digit_q.push_back('{CHAR_NONE, STATUS_BAD_BASE, 1'b1});
        end else if (value == '0) begin
            digit_q.push_back('{CHAR_ZERO, STATUS_OK, 1'b1});
        end else begin
            quo = value;
            while (quo != '0 && n < MAX_DIGITS_DEF) begin
                rems[n] = REM_W'(quo % VALUE_W'(radix));
                quo     = quo / VALUE_W'(radix);
                n++;
            end
            for (int k = n - 1; k >= 0; k--) begin
                d = rems[k];
                if (d < 6'd10) begin
                    ch = CHAR_ZERO + CHAR_W'(d);
                end else if (d < 6'd36) begin
                    ch = CHAR_A + CHAR_W'(d - 6'd10);
                end else begin
                    ch = CHAR_NONE;
                end
                digit_q.push_back('{ch, STATUS_OK, (k == 0)});
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_rec want;
        if (!i_rst_n) begin
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_digits(i_s_tdata[31:0], i_s_tdata[39:32]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (digit_q.size() == 0) begin
                    $error("digit with no request waiting: digit_char %h", i_m_tdata[6:0]);
                    o_fail_count++;
                end else begin
                    want = digit_q.pop_front();
                    if (i_m_tdata[6:0] !== want.ch) begin
                        $error("digit_char expected %h actual %h", want.ch, i_m_tdata[6:0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[7] !== 1'b0) begin
                        $error("tdata zero fill expected 0 actual %b", i_m_tdata[7]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[0] !== want.status) begin
                        $error("status expected %b actual %b", want.status, i_m_tuser[0]);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_digit expected %b actual %b", want.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding = digit_q.size();
    end

endmodule

@@ verif/radix_digit_converter_core_tb.sv @@
// Testbench top for the radix digit converter: clock, reset, request stimulus and the
// output-side ready pattern. Depends on rdc_pkg, radix_digit_converter_core, rdc_digit_checker.
`timescale 1ns / 1ps

module radix_digit_converter_core_tb;
    import rdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int          RAND_PER_PHASE = 90;
    localparam int          HOLD_CYCLES  = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    radix_digit_converter_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    rdc_digit_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Output side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(negedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one request and holds it until accepted; returns at a falling edge with
    // tvalid still high unless an idle gap follows.
    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [BASE_W-1:0] radix);
        s_tdata  <= {radix, value};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), 32'($urandom)};
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    initial begin
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  radix;
        logic [VALUE_W-1:0] pw;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, zero number, invalid radixes, table edges.
        send_request(32'd0, 8'd10);
        send_request(32'd0, 8'd36);
        send_request(32'hFFFF_FFFF, 8'd2);
        send_request(32'hFFFF_FFFF, 8'd36);
        send_request(32'hFFFF_FFFF, 8'd16);
        send_request(32'h8000_0000, 8'd2);
        send_request(32'd1, 8'd2);
        send_request(32'd1, 8'd36);
        send_request(32'd35, 8'd36);
        send_request(32'd36, 8'd36);
        send_request(32'd10, 8'd11);
        send_request(32'd12345, 8'd10);
        send_request(32'hFFFF_FFFF, 8'd3);
        send_request(32'hDEAD_BEEF, 8'd7);
        send_request(32'd123, 8'd0);
        send_request(32'd0, 8'd1);
        send_request(32'hFFFF_FFFF, 8'd37);
        send_request(32'h5555_5555, 8'd255);
        send_request(32'hAAAA_AAAA, 8'd128);
        send_request(32'd0, 8'd0);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            // Receiver holds off while requests keep coming, so the block backs up.
            if (phase == 1 || phase == 3) hold_toggle = ~hold_toggle;
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if ($urandom_range(9) == 0) begin
                    radix = ($urandom_range(1) != 0) ? 8'($urandom_range(0, 1))
                                                     : 8'($urandom_range(37, 255));
                end else begin
                    radix = 8'($urandom_range(2, 36));
                end
                case ($urandom_range(4))
                    0: value = $urandom;
                    1: value = $urandom_range(0, 1000);
                    2: value = $urandom >> $urandom_range(0, 31);
                    3: begin
                        // A power of the radix, or one below it: a digit-count boundary.
                        pw = 32'd1;
                        repeat ($urandom_range(1, 8)) pw = pw * ((radix > 1) ? radix : 8'd2);
                        value = pw - 32'($urandom_range(1));
                    end
                    default: value = 32'd0;
                endcase
                send_request(value, radix);
            end
            drain_results();
        end

        repeat (50) @(negedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
